FILE: src/snt_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the sigmoid table generator for the neuron trainer.
// No dependencies.
package snt_pkg;

  localparam int NUM_INPUTS_DEF = 4;
  localparam int SIG_DEPTH_DEF  = 256;
  localparam int FEAT_FIELDS    = 4;

  localparam int F_W    = 16;  // feature, Q4.12
  localparam int W_W    = 24;  // weight, Q12.12
  localparam int P_W    = 13;  // prediction, unsigned Q1.12
  localparam int TGT_W  = 13;
  localparam int TOL_W  = 13;
  localparam int LR_W   = 16;
  localparam int IDX_W  = 3;
  localparam int ELR_W  = 31;  // error times rate
  localparam int PROD_W = 47;
  localparam int ACC_W  = 48;
  localparam int S_W    = 32;
  localparam int Z_SPAN = 32768;

  localparam logic [TOL_W-1:0] TENTH_TOL = TOL_W'(410);
  localparam logic [LR_W-1:0]  TENTH_LR  = LR_W'(410);

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } snt_op_t;

  localparam logic [1:0] CFG_TOL = 2'd0;
  localparam logic [1:0] CFG_LR  = 2'd1;

  typedef struct packed {
    logic mul_dot;
    logic mul_upd;
    logic apply;
    logic wr_en;
  } snt_lane_ctl_t;

  // Table entry 4096 / (1 + e^-z), z in Q.12; evaluated at elaboration only.
  function automatic logic [P_W-1:0] sig_val(input longint unsigned z);
    longint unsigned c [16];
    longint unsigned e;
    longint unsigned d;
    longint unsigned n;
    longint unsigned q;
    longint unsigned rem;
    c[0] = 64'd1073479712;
    for (int j = 0; j < 15; j++) begin
      c[j+1] = (c[j] * c[j] + (64'd1 << 29)) >> 30;
    end
    e = 64'd1 << 30;
    for (int j = 0; j < 16; j++) begin
      if (((z >> j) & 64'd1) != 64'd0) e = (e * c[j] + (64'd1 << 29)) >> 30;
    end
    d = (64'd1 << 30) + e;
    n = (64'd1 << 42) + (d >> 1);
    q = 64'd0;
    rem = 64'd0;
    for (int i = 43; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q = q | (64'd1 << i);
      end
    end
    return P_W'(q);
  endfunction

endpackage

FILE: src/snt_lane.sv
`timescale 1ns / 1ps
// One weight lane: holds a feature weight, multiplies for the dot product
// and for the delta-rule step, applies the saturated update. Uses snt_pkg.
module snt_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  snt_pkg::snt_lane_ctl_t                ctl,
  input  logic signed [snt_pkg::F_W-1:0]        feat,
  input  logic signed [snt_pkg::ELR_W-1:0]      elr,
  input  logic signed [snt_pkg::W_W-1:0]        wr_data,
  output logic signed [snt_pkg::PROD_W-1:0]     prod
);
  import snt_pkg::*;

  logic signed [W_W-1:0]    weight_r, weight_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ELR_W-1:0]  mult_a;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] step_full;
  logic signed [W_W:0]      sum;

  assign mult_a    = ctl.mul_upd ? elr : ELR_W'(weight_r);
  assign prod_nxt  = PROD_W'(mult_a) * PROD_W'(feat);
  assign step_full = (prod_r + (PROD_W'(1) <<< 23)) >>> 24;
  assign sum       = (W_W+1)'(weight_r) + (W_W+1)'(step_full);

  always_comb begin
    weight_nxt = weight_r;
    if (ctl.wr_en) begin
      weight_nxt = wr_data;
    end else if (ctl.apply) begin
      // saturate to the weight range
      if (sum[W_W] != sum[W_W-1]) weight_nxt = sum[W_W] ? {1'b1, {(W_W-1){1'b0}}}
                                                         : {1'b0, {(W_W-1){1'b1}}};
      else weight_nxt = sum[W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_dot || ctl.mul_upd) prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

FILE: src/snt_sigmoid.sv
`timescale 1ns / 1ps
// Two-stage interpolated sigmoid: table lookup, then linear interpolation.
// Uses snt_pkg for the table generator.
module snt_sigmoid #(
  parameter int SIGMOID_TABLE_DEPTH = snt_pkg::SIG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            en_look,
  input  logic                            en_intp,
  input  logic signed [snt_pkg::S_W-1:0]  s,
  output logic [snt_pkg::P_W-1:0]         pred
);
  import snt_pkg::*;

  localparam int TI_W = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int PP_W = 15 + $clog2(SIGMOID_TABLE_DEPTH + 1);

  logic [P_W-1:0] tab [0:SIGMOID_TABLE_DEPTH];

  for (genvar k = 0; k <= SIGMOID_TABLE_DEPTH; k++) begin : g_tab
    localparam longint Z = (longint'(k) * Z_SPAN) / SIGMOID_TABLE_DEPTH;
    assign tab[k] = sig_val(Z);
  end

  logic [S_W:0]        a;
  logic [PP_W-1:0]     p;
  logic [TI_W-1:0]     idx;
  logic                sat;
  logic [P_W-1:0]      lo_r;
  logic signed [13:0]  dlt_r;
  logic [14:0]         f_r;
  logic                neg_r;
  logic signed [29:0]  ip;
  logic signed [14:0]  r;

  assign a   = s[S_W-1] ? (S_W+1)'(-(S_W+1)'(s)) : (S_W+1)'(s);
  assign sat = a >= (S_W+1)'(Z_SPAN);
  assign p   = PP_W'(a[14:0]) * PP_W'(SIGMOID_TABLE_DEPTH);
  assign idx = TI_W'(p >> 15);

  always_ff @(posedge clk) begin
    if (en_look) begin
      neg_r <= s[S_W-1];
      if (sat) begin
        lo_r  <= tab[SIGMOID_TABLE_DEPTH];
        dlt_r <= '0;
        f_r   <= '0;
      end else begin
        lo_r  <= tab[idx];
        dlt_r <= 14'(tab[idx + TI_W'(1)]) - 14'(tab[idx]);
        f_r   <= p[14:0];
      end
    end
  end

  assign ip = 30'(dlt_r) * $signed({15'd0, f_r});
  assign r  = 15'(lo_r) + 15'((ip + 30'sd16384) >>> 15);

  always_ff @(posedge clk) begin
    if (en_intp) pred <= neg_r ? P_W'(15'sd4096 - r) : P_W'(r);
  end

endmodule

FILE: src/sigmoid_neuron_trainer.sv
`timescale 1ns / 1ps
// Top level of the logistic neuron trainer: control sequencer, weight lanes,
// merge of lane products and bias, sigmoid unit. Uses snt_pkg, snt_lane, snt_sigmoid.
//
// Usage:
//  in_*  : one word per item; in_tuser holds the opcode (predict, train,
//          write one weight), in_tdata the features, target and weight write.
//  out_* : one word per item; out_tdata holds the prediction, out_tuser the
//          within-tolerance flag of a train.
//  cfg_* : register writes (0 tolerance, 1 learning rate), always ready.
//  A predict runs the steps dot, sum, lookup, interpolate, check and done; a
//  train that updates adds update multiply and apply, and a weight write goes
//  straight to done. The next word is taken the cycle after the result is
//  registered, so items never overlap; the chain of multiply, lane merge, two
//  sigmoid stages, error product and update multiply sets this, as each train
//  changes the weights that the next item reads.
//  The result register holds a finished word while the receiver stalls; the
//  sequencer waits in its final step only if a second result would overwrite it.
//  Reset clears all weights to zero and sets tolerance and rate to 0.1.
module sigmoid_neuron_trainer #(
  parameter int NUM_INPUTS          = snt_pkg::NUM_INPUTS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = snt_pkg::SIG_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // input_value_0..3 [63:0], target [76:64], weight_index [79:77],
  // weight_value [103:80]
  input  logic [103:0] in_tdata,
  // op [1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // prediction [12:0], zero padding [15:13]
  output logic [15:0]  out_tdata,
  // within_tolerance [0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import snt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT, ST_SUM, ST_LOOK, ST_INTP, ST_CHK, ST_UMUL, ST_UAPP, ST_DONE
  } state_t;

  state_t state_r;
  logic [TOL_W-1:0] tol_r;
  logic [LR_W-1:0]  lr_r;
  logic signed [F_W-1:0] feat_r [NUM_INPUTS];
  logic [TGT_W-1:0] tgt_r;
  logic             train_r;
  logic signed [W_W-1:0] bias_r;
  logic signed [S_W-1:0] s_r;
  logic signed [ELR_W-1:0] elr_r;
  logic [P_W-1:0]   res_pred_r;
  logic             res_ok_r;
  logic             out_tvalid_r;
  logic [P_W-1:0]   out_pred_r;
  logic             out_ok_r;

  snt_lane_ctl_t           ctl [NUM_INPUTS];
  logic signed [PROD_W-1:0] prod [NUM_INPUTS];
  logic [P_W-1:0]   pred;
  logic             in_acc;
  logic [IDX_W-1:0] widx;
  logic signed [W_W-1:0] wval;
  logic             wr_ok;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0] lo_b, hi_b, pv;
  logic signed [13:0] err;
  logic [TOL_W-1:0] tol_e;
  logic [LR_W-1:0]  lr_e;
  logic signed [ELR_W-1:0] bstep;
  logic signed [W_W:0] bsum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign widx       = in_tdata[79:77];
  assign wval       = in_tdata[103:80];
  assign wr_ok      = (snt_op_t'(in_tuser) == OP_WRITE) && (int'(widx) <= NUM_INPUTS);

  for (genvar k = 0; k < NUM_INPUTS; k++) begin : g_lane
    always_comb begin
      ctl[k].mul_dot = (state_r == ST_DOT);
      ctl[k].mul_upd = (state_r == ST_UMUL);
      ctl[k].apply   = (state_r == ST_UAPP);
      ctl[k].wr_en   = in_acc && wr_ok && (int'(widx) == k);
    end

    always_ff @(posedge clk) begin
      if (in_acc) begin
        if (k < FEAT_FIELDS) feat_r[k] <= in_tdata[F_W*(k % FEAT_FIELDS) +: F_W];
        else feat_r[k] <= '0;
      end
    end

    snt_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[k]),
      .feat    (feat_r[k]),
      .elr     (elr_r),
      .wr_data (wval),
      .prod    (prod[k])
    );
  end

  snt_sigmoid #(
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_sig (
    .clk     (clk),
    .en_look (state_r == ST_LOOK),
    .en_intp (state_r == ST_INTP),
    .s       (s_r),
    .pred    (pred)
  );

  // merge lane products with the bias
  always_comb begin
    acc = ACC_W'(bias_r) <<< 12;
    for (int k = 0; k < NUM_INPUTS; k++) acc = acc + ACC_W'(prod[k]);
  end

  assign tol_e = (tol_r == '0) ? TENTH_TOL : tol_r;
  assign lr_e  = (lr_r == '0) ? TENTH_LR : lr_r;
  assign pv    = 16'(pred);
  assign lo_b  = 16'(tgt_r) - 16'(tol_e);
  assign hi_b  = 16'(tgt_r) + 16'(tol_e);
  assign err   = 14'(tgt_r) - 14'(pred);
  assign bstep = (elr_r + ELR_W'(2048)) >>> 12;
  assign bsum  = (W_W+1)'(bias_r) + (W_W+1)'(bstep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tol_r        <= TENTH_TOL;
      lr_r         <= TENTH_LR;
      bias_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOL) tol_r <= cfg_data[TOL_W-1:0];
        else if (cfg_index == CFG_LR) lr_r <= cfg_data[LR_W-1:0];
      end
      if (out_tvalid_r && out_tready && state_r != ST_DONE) out_tvalid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_pred_r <= '0;
            res_ok_r   <= 1'b0;
            train_r    <= (snt_op_t'(in_tuser) == OP_TRAIN);
            tgt_r      <= in_tdata[76:64];
            unique case (snt_op_t'(in_tuser))
              OP_PREDICT, OP_TRAIN: state_r <= ST_DOT;
              OP_WRITE: begin
                if (wr_ok && int'(widx) == NUM_INPUTS) bias_r <= wval;
                state_r <= ST_DONE;
              end
              OP_NONE: state_r <= ST_DONE;
            endcase
          end
        end
        ST_DOT: state_r <= ST_SUM;
        ST_SUM: begin
          s_r     <= S_W'((acc + ACC_W'(2048)) >>> 12);
          state_r <= ST_LOOK;
        end
        ST_LOOK: state_r <= ST_INTP;
        ST_INTP: state_r <= ST_CHK;
        ST_CHK: begin
          res_pred_r <= pred;
          if (!train_r) begin
            state_r <= ST_DONE;
          end else if (lo_b <= pv && pv <= hi_b) begin
            res_ok_r <= 1'b1;
            state_r  <= ST_DONE;
          end else begin
            elr_r   <= ELR_W'(err) * ELR_W'($signed({1'b0, lr_e}));
            state_r <= ST_UMUL;
          end
        end
        ST_UMUL: state_r <= ST_UAPP;
        ST_UAPP: begin
          if (bsum[W_W] != bsum[W_W-1]) bias_r <= bsum[W_W] ? {1'b1, {(W_W-1){1'b0}}}
                                                             : {1'b0, {(W_W-1){1'b1}}};
          else bias_r <= bsum[W_W-1:0];
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_pred_r   <= res_pred_r;
            out_ok_r     <= res_ok_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_pred_r};
  assign out_tuser  = out_ok_r;

endmodule
